@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while reset is held.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is held.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/dda_pkg.sv @@
`timescale 1ns / 1ps

package dda_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    localparam int POS_W = COORD_BITS + FRAC_BITS + 1;
    localparam int QUO_W = FRAC_BITS + 1;
    localparam int INC_W = FRAC_BITS + 2;
    localparam int CNT_W = $clog2(QUO_W + 1);

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    localparam logic [POS_W:0] ROUND_HALF = (POS_W + 1)'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic                  operation;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
    } in_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  last_pixel;
    } out_item_t;

    typedef struct packed {
        logic                  start;
        logic [COORD_BITS-1:0] dividend;
        logic [COORD_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

    // Rounds half up and saturates to the coordinate range.
    function automatic logic [COORD_BITS-1:0] round_pixel(input logic [POS_W-1:0] pos);
        logic [POS_W:0] p;
        logic [COORD_BITS-1:0] res;
        p = {pos[POS_W-1], pos} + ROUND_HALF;
        if (p[POS_W]) begin
            res = '0;
        end else if (|p[POS_W-1:FRAC_BITS+COORD_BITS]) begin
            res = '1;
        end else begin
            res = p[FRAC_BITS +: COORD_BITS];
        end
        return res;
    endfunction

endpackage

@@ sv/dda_divider.sv @@
`timescale 1ns / 1ps

module dda_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  dda_pkg::div_req_t req,
    output dda_pkg::div_rsp_t rsp
);

    logic [dda_pkg::COORD_BITS:0]   rem_reg, rem_next;
    logic [dda_pkg::COORD_BITS-1:0] den_reg, den_next;
    logic [dda_pkg::QUO_W-1:0]      quo_reg, quo_next;
    logic [dda_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic                           ge;
    logic [dda_pkg::COORD_BITS:0]   diff;

    always_comb begin
        ge   = rem_reg >= {1'b0, den_reg};
        diff = ge ? rem_reg - {1'b0, den_reg} : rem_reg;

        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start) begin
            rem_next  = {1'b0, req.dividend};
            den_next  = req.divisor;
            quo_next  = '0;
            cnt_next  = dda_pkg::CNT_W'(dda_pkg::QUO_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = {diff[dda_pkg::COORD_BITS-1:0], 1'b0};
            quo_next = {quo_reg[dda_pkg::QUO_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == dda_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ sv/dda_line_rasterizer.sv @@
`timescale 1ns / 1ps

// Channel   Ports                       Direction  Carries
// input     s_valid, s_ready, s_item    in         load or advance item
// result    m_valid, m_ready, m_item    out        one pixel
//
// An advance item on an active line registers its pixel for the next cycle.
// A load item emits its start pixel at once; for a line of nonzero length it then holds
// s_ready low while the shared divider forms both increments, one quotient bit per cycle.
// Reset is synchronous and active low; it drops any pending result and any active line.
// A stalled result holds s_ready low until it is taken.

module dda_line_rasterizer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dda_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output dda_pkg::out_item_t m_item
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y
    } state_t;

    state_t                         state_reg, state_next;
    logic [dda_pkg::POS_W-1:0]      x_pos_reg, x_pos_next;
    logic [dda_pkg::POS_W-1:0]      y_pos_reg, y_pos_next;
    logic [dda_pkg::INC_W-1:0]      x_inc_reg, x_inc_next;
    logic [dda_pkg::INC_W-1:0]      y_inc_reg, y_inc_next;
    logic [dda_pkg::COORD_BITS-1:0] steps_left_reg, steps_left_next;
    logic [dda_pkg::COORD_BITS-1:0] abs_y_reg, abs_y_next;
    logic                           neg_x_reg, neg_x_next;
    logic                           neg_y_reg, neg_y_next;
    logic                           active_reg, active_next;
    logic                           m_valid_reg, m_valid_next;
    dda_pkg::out_item_t             m_item_reg, m_item_next;

    dda_pkg::div_req_t              div_req;
    dda_pkg::div_rsp_t              div_rsp;

    logic                           accept;
    logic [dda_pkg::COORD_BITS:0]   dx, dy;
    logic [dda_pkg::COORD_BITS-1:0] abs_x, abs_y, steps;
    logic [dda_pkg::INC_W-1:0]      quo_ext, quo_signed;
    logic [dda_pkg::POS_W-1:0]      x_sum, y_sum;

    dda_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        dx    = {1'b0, s_item.x_end} - {1'b0, s_item.x_start};
        dy    = {1'b0, s_item.y_end} - {1'b0, s_item.y_start};
        abs_x = dx[dda_pkg::COORD_BITS] ? dda_pkg::COORD_BITS'(-dx)
                                        : dx[dda_pkg::COORD_BITS-1:0];
        abs_y = dy[dda_pkg::COORD_BITS] ? dda_pkg::COORD_BITS'(-dy)
                                        : dy[dda_pkg::COORD_BITS-1:0];
        steps = (abs_x > abs_y) ? abs_x : abs_y;

        x_sum = x_pos_reg + {{(dda_pkg::POS_W - dda_pkg::INC_W){x_inc_reg[dda_pkg::INC_W-1]}},
                             x_inc_reg};
        y_sum = y_pos_reg + {{(dda_pkg::POS_W - dda_pkg::INC_W){y_inc_reg[dda_pkg::INC_W-1]}},
                             y_inc_reg};

        quo_ext    = {1'b0, div_rsp.quotient};
        quo_signed = ((state_reg == ST_DIV_X) ? neg_x_reg : neg_y_reg) ? -quo_ext : quo_ext;

        div_req.start    = 1'b0;
        div_req.dividend = abs_x;
        div_req.divisor  = steps;

        state_next      = state_reg;
        x_pos_next      = x_pos_reg;
        y_pos_next      = y_pos_reg;
        x_inc_next      = x_inc_reg;
        y_inc_next      = y_inc_reg;
        steps_left_next = steps_left_reg;
        abs_y_next      = abs_y_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        active_next     = active_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_item.operation == dda_pkg::OP_LOAD) begin
                        x_pos_next = {1'b0, s_item.x_start, {dda_pkg::FRAC_BITS{1'b0}}};
                        y_pos_next = {1'b0, s_item.y_start, {dda_pkg::FRAC_BITS{1'b0}}};
                        steps_left_next = steps;
                        abs_y_next      = abs_y;
                        neg_x_next      = dx[dda_pkg::COORD_BITS];
                        neg_y_next      = dy[dda_pkg::COORD_BITS];
                        m_valid_next        = 1'b1;
                        m_item_next.pixel_x = s_item.x_start;
                        m_item_next.pixel_y = s_item.y_start;
                        if (steps == '0) begin
                            x_inc_next  = '0;
                            y_inc_next  = '0;
                            active_next = 1'b0;
                            m_item_next.last_pixel = 1'b1;
                        end else begin
                            active_next   = 1'b1;
                            div_req.start = 1'b1;
                            state_next    = ST_DIV_X;
                            m_item_next.last_pixel = 1'b0;
                        end
                    end else if (active_reg) begin
                        x_pos_next      = x_sum;
                        y_pos_next      = y_sum;
                        steps_left_next = steps_left_reg - 1'b1;
                        m_valid_next        = 1'b1;
                        m_item_next.pixel_x = dda_pkg::round_pixel(x_sum);
                        m_item_next.pixel_y = dda_pkg::round_pixel(y_sum);
                        if (steps_left_reg == dda_pkg::COORD_BITS'(1)) begin
                            active_next = 1'b0;
                            m_item_next.last_pixel = 1'b1;
                        end else begin
                            m_item_next.last_pixel = 1'b0;
                        end
                    end
                end
            end
            ST_DIV_X: begin
                div_req.dividend = abs_y_reg;
                div_req.divisor  = steps_left_reg;
                if (div_rsp.done) begin
                    x_inc_next    = quo_signed;
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                div_req.dividend = abs_y_reg;
                div_req.divisor  = steps_left_reg;
                if (div_rsp.done) begin
                    y_inc_next = quo_signed;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        x_pos_reg  <= x_pos_next;
        y_pos_reg  <= y_pos_next;
        x_inc_reg  <= x_inc_next;
        y_inc_reg  <= y_inc_next;
        abs_y_reg  <= abs_y_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        m_item_reg <= m_item_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            steps_left_reg <= '0;
            active_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            steps_left_reg <= steps_left_next;
            active_reg     <= active_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

@@ sv/dda_checker.sv @@
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dda_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input dda_pkg::in_item_t  s_item,
    input logic               m_valid,
    input logic               m_ready,
    input dda_pkg::out_item_t m_item
);

    logic load_acc;
    logic zero_len;

    assign load_acc = s_valid && s_ready && (s_item.operation == dda_pkg::OP_LOAD);
    assign zero_len = (s_item.x_start == s_item.x_end) && (s_item.y_start == s_item.y_end);

    `ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_item), "result changed while stalled")
    `ASSERT_NEXT(a_load_start_pixel, load_acc, m_valid && m_item.pixel_x == $past(s_item.x_start) && m_item.pixel_y == $past(s_item.y_start), "load did not emit its start pixel")
    `ASSERT_NEXT(a_point_is_last, load_acc && zero_len, m_item.last_pixel, "zero-length line not flagged last")
    `ASSERT_NEXT(a_line_busy, load_acc && !zero_len, !s_ready && !m_item.last_pixel, "line load did not start the increment division")

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (.*);

@@ tb/sv/dda_line_rasterizer_tb.sv @@
`timescale 1ns / 1ps

module dda_line_rasterizer_tb;

    import dda_pkg::*;

    localparam int  COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int  DRAIN_WAIT = 100;
    localparam longint CYCLE_LIMIT = 400000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Line state of the expected pixel stream.
    logic signed [POS_W-1:0] x_pos_q;
    logic signed [POS_W-1:0] y_pos_q;
    logic signed [INC_W-1:0] x_inc_q;
    logic signed [INC_W-1:0] y_inc_q;
    logic [COORD_BITS:0]     steps_left_q;
    bit                      line_on;

    out_item_t pixel_queue[$];
    int        fail_count = 0;
    int        sent_count = 0;
    longint    cycle_count = 0;
    bit        gaps_on = 1'b1;
    int        stall_left = 0;

    dda_line_rasterizer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int line_steps(input int xs, input int ys, input int xe, input int ye);
        int ax;
        int ay;
        ax = (xe > xs) ? xe - xs : xs - xe;
        ay = (ye > ys) ? ye - ys : ys - ye;
        return (ax > ay) ? ax : ay;
    endfunction

    // Half-up rounding of a fixed-point position, clamped to the pixel grid.
    function automatic logic [COORD_BITS-1:0] nearest_pixel(input logic signed [POS_W-1:0] pos);
        longint p;
        p = longint'(pos) + (longint'(1) << (FRAC_BITS - 1));
        if (p < 0) begin
            return '0;
        end
        p = p >>> FRAC_BITS;
        if (p > COORD_MAX) begin
            return '1;
        end
        return p[COORD_BITS-1:0];
    endfunction

    task automatic track_item(input in_item_t it);
        int        xs;
        int        ys;
        int        dx;
        int        dy;
        int        steps;
        longint    one_q;
        out_item_t px;
        one_q = longint'(1) << FRAC_BITS;
        if (it.operation == OP_LOAD) begin
            xs    = int'(it.x_start);
            ys    = int'(it.y_start);
            dx    = int'(it.x_end) - xs;
            dy    = int'(it.y_end) - ys;
            steps = line_steps(xs, ys, int'(it.x_end), int'(it.y_end));
            x_pos_q = POS_W'(longint'(xs) * one_q);
            y_pos_q = POS_W'(longint'(ys) * one_q);
            if (steps == 0) begin
                x_inc_q      = '0;
                y_inc_q      = '0;
                steps_left_q = '0;
                line_on      = 1'b0;
                px.last_pixel = 1'b1;
            end else begin
                x_inc_q      = INC_W'((longint'(dx) * one_q) / longint'(steps));
                y_inc_q      = INC_W'((longint'(dy) * one_q) / longint'(steps));
                steps_left_q = (COORD_BITS + 1)'(steps);
                line_on      = 1'b1;
                px.last_pixel = 1'b0;
            end
        end else begin
            if (!line_on) begin
                return;
            end
            x_pos_q      = x_pos_q + x_inc_q;
            y_pos_q      = y_pos_q + y_inc_q;
            steps_left_q = steps_left_q - 1'b1;
            line_on      = (steps_left_q != 0);
            px.last_pixel = !line_on;
        end
        px.pixel_x = nearest_pixel(x_pos_q);
        px.pixel_y = nearest_pixel(y_pos_q);
        pixel_queue.push_back(px);
    endtask

    always @(posedge aclk) begin
        out_item_t got;
        out_item_t want;
        cycle_count++;
        if (!aresetn) begin
            x_pos_q      = '0;
            y_pos_q      = '0;
            x_inc_q      = '0;
            y_inc_q      = '0;
            steps_left_q = '0;
            line_on      = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                track_item(s_item);
            end
            if (m_valid && m_ready) begin
                got = m_item;
                if (pixel_queue.size() == 0) begin
                    $error("unexpected pixel x=%0d y=%0d last=%0d",
                           got.pixel_x, got.pixel_y, got.last_pixel);
                    fail_count++;
                end else begin
                    want = pixel_queue.pop_front();
                    if (got.pixel_x !== want.pixel_x) begin
                        $error("pixel_x expected %0d, got %0d", want.pixel_x, got.pixel_x);
                        fail_count++;
                    end
                    if (got.pixel_y !== want.pixel_y) begin
                        $error("pixel_y expected %0d, got %0d", want.pixel_y, got.pixel_y);
                        fail_count++;
                    end
                    if (got.last_pixel !== want.last_pixel) begin
                        $error("last_pixel expected %0d, got %0d",
                               want.last_pixel, got.last_pixel);
                        fail_count++;
                    end
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (gaps_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9);
        end
        if (gaps_on && stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            stall_left = 0;
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input in_item_t it);
        int gap;
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    function automatic in_item_t random_item(input logic op);
        in_item_t it;
        it.operation = op;
        it.x_start   = COORD_BITS'($urandom_range(0, COORD_MAX));
        it.y_start   = COORD_BITS'($urandom_range(0, COORD_MAX));
        it.x_end     = COORD_BITS'($urandom_range(0, COORD_MAX));
        it.y_end     = COORD_BITS'($urandom_range(0, COORD_MAX));
        return it;
    endfunction

    task automatic load_line(input int xs, input int ys, input int xe, input int ye);
        in_item_t it;
        it.operation = OP_LOAD;
        it.x_start   = COORD_BITS'(xs);
        it.y_start   = COORD_BITS'(ys);
        it.x_end     = COORD_BITS'(xe);
        it.y_end     = COORD_BITS'(ye);
        send_item(it);
    endtask

    task automatic advance(input int count);
        repeat (count) send_item(random_item(OP_ADVANCE));
    endtask

    function automatic int offset_coord(input int c, input int span);
        int e;
        e = $urandom_range(0, 1) ? c + int'($urandom_range(0, span))
                                 : c - int'($urandom_range(0, span));
        if (e > COORD_MAX) begin
            e = COORD_MAX;
        end
        if (e < 0) begin
            e = 0;
        end
        return e;
    endfunction

    task automatic test_advance_while_idle();
        send_item('{operation: OP_ADVANCE, x_start: '1, y_start: '1, x_end: '1, y_end: '1});
        advance(1);
    endtask

    task automatic test_extreme_lines();
        load_line(0, 0, COORD_MAX, COORD_MAX);
        advance(2);
        load_line(COORD_MAX, 0, 0, COORD_MAX);
        advance(1);
    endtask

    task automatic test_zero_length();
        load_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        load_line(0, 0, 0, 0);
        advance(1);
    endtask

    task automatic test_full_lines();
        load_line(10, 20, 14, 22);
        advance(5);
        load_line(100, 100, 98, 105);
        advance(5);
    endtask

    task automatic test_reload_mid_line();
        load_line(0, 0, 100, 50);
        advance(2);
        load_line(50, 50, 48, 52);
        advance(2);
    endtask

    task automatic run_random_lines(input int item_goal);
        int first;
        int pick;
        int span;
        int xs;
        int ys;
        int xe;
        int ye;
        int steps;
        int count;
        first = sent_count;
        while (sent_count - first < item_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_item(random_item(1'($urandom_range(0, 1))));
            end else begin
                span = (pick < 70) ? 16 : (pick < 90) ? 200 : COORD_MAX;
                xs = $urandom_range(0, COORD_MAX);
                ys = $urandom_range(0, COORD_MAX);
                xe = offset_coord(xs, span);
                ye = offset_coord(ys, span);
                load_line(xs, ys, xe, ye);
                steps = line_steps(xs, ys, xe, ye);
                if (steps <= 64 && $urandom_range(0, 4) != 0) begin
                    count = steps;
                    if ($urandom_range(0, 5) == 0) begin
                        count += $urandom_range(1, 3);
                    end
                end else begin
                    count = $urandom_range(0, (steps < 40) ? steps : 40);
                end
                advance(count);
            end
        end
    endtask

    task automatic test_random_with_idling();
        gaps_on = 1'b1;
        run_random_lines(600);
    endtask

    task automatic test_random_full_rate();
        gaps_on = 1'b0;
        run_random_lines(100);
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        test_advance_while_idle();
        test_extreme_lines();
        test_zero_length();
        test_full_lines();
        test_reload_mid_line();
        test_random_with_idling();
        test_random_full_rate();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0 && pixel_queue.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/dda_pkg.sv
sv/dda_divider.sv
sv/dda_line_rasterizer.sv
sv/dda_checker.sv
tb/sv/dda_line_rasterizer_tb.sv
